// ===== rtl/core/mcs51pd_pkg.sv =====
`timescale 1ns / 1ps

package mcs51pd_pkg;

  // Argument kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_NONE    = 4'd0,
    KIND_ADDR11  = 4'd1,
    KIND_ADDR16  = 4'd2,
    KIND_DIRECT  = 4'd3,
    KIND_IMMED   = 4'd4,
    KIND_IMMED16 = 4'd5,
    KIND_BIT     = 4'd6,
    KIND_REL     = 4'd7,
    KIND_IMPL    = 4'd8
  } arg_kind_t;

  // One entry of the opcode decode table.
  typedef struct packed {
    logic [1:0] len;
    arg_kind_t  k1;
    arg_kind_t  k2;
    logic       jump;
    logic       cond;
  } dec_entry_t;

  localparam logic [19:0] PAGE_MASK        = 20'h0FF800;
  localparam logic [7:0]  ADDR11_PAGE_BITS = 8'hE0;
  localparam logic [15:0] BANK_SIZE        = 16'h4000;
  localparam logic [19:0] BANK0_BASE       = 20'h10000;
  localparam logic [19:0] BANK1_BASE       = 20'h14000;
  localparam logic [19:0] BANK2_BASE       = 20'h18000;
  localparam logic [19:0] BANK3_BASE       = 20'h1C000;

  localparam dec_entry_t ENT_O1 =
    '{len: 2'd1, k1: KIND_NONE, k2: KIND_NONE, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_AJ =
    '{len: 2'd2, k1: KIND_ADDR11, k2: KIND_NONE, jump: 1'b1, cond: 1'b0};
  localparam dec_entry_t ENT_AC =
    '{len: 2'd2, k1: KIND_ADDR11, k2: KIND_NONE, jump: 1'b0, cond: 1'b1};
  localparam dec_entry_t ENT_LJMP =
    '{len: 2'd3, k1: KIND_ADDR16, k2: KIND_NONE, jump: 1'b1, cond: 1'b0};
  localparam dec_entry_t ENT_LCALL =
    '{len: 2'd3, k1: KIND_ADDR16, k2: KIND_NONE, jump: 1'b0, cond: 1'b1};
  localparam dec_entry_t ENT_SJMP =
    '{len: 2'd2, k1: KIND_REL, k2: KIND_NONE, jump: 1'b1, cond: 1'b0};
  localparam dec_entry_t ENT_RC =
    '{len: 2'd2, k1: KIND_REL, k2: KIND_NONE, jump: 1'b0, cond: 1'b1};
  localparam dec_entry_t ENT_D2 =
    '{len: 2'd2, k1: KIND_DIRECT, k2: KIND_NONE, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_I2 =
    '{len: 2'd2, k1: KIND_IMMED, k2: KIND_NONE, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_B2 =
    '{len: 2'd2, k1: KIND_BIT, k2: KIND_NONE, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_DX =
    '{len: 2'd2, k1: KIND_DIRECT, k2: KIND_IMPL, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_DI =
    '{len: 2'd3, k1: KIND_DIRECT, k2: KIND_IMMED, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_DD =
    '{len: 2'd3, k1: KIND_DIRECT, k2: KIND_DIRECT, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_DPTR =
    '{len: 2'd3, k1: KIND_IMMED16, k2: KIND_NONE, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_BX =
    '{len: 2'd2, k1: KIND_BIT, k2: KIND_IMPL, jump: 1'b0, cond: 1'b0};
  localparam dec_entry_t ENT_BR =
    '{len: 2'd3, k1: KIND_BIT, k2: KIND_REL, jump: 1'b0, cond: 1'b1};
  localparam dec_entry_t ENT_IR =
    '{len: 2'd3, k1: KIND_IMMED, k2: KIND_REL, jump: 1'b0, cond: 1'b1};
  localparam dec_entry_t ENT_DR =
    '{len: 2'd3, k1: KIND_DIRECT, k2: KIND_REL, jump: 1'b0, cond: 1'b1};

  // Opcode decode table. AJMP/ACALL sit in every row at low nibble 1; the
  // register-indexed columns (low nibble 6 and up) repeat within a row, except row D, which splits at low nibble 8.
  function automatic dec_entry_t decode_entry(input logic [7:0] op);
    dec_entry_t e;
    e = ENT_O1;
    if (op[3:0] == 4'h1) begin
      e = op[4] ? ENT_AC : ENT_AJ;
    end else if (op[3:0] >= 4'h6) begin
      unique case (op[7:4])
        4'h7:    e = ENT_I2;
        4'h8:    e = ENT_DX;
        4'hA:    e = ENT_D2;
        4'hB:    e = ENT_IR;
        4'hD:    e = op[3] ? ENT_RC : ENT_O1;
        default: e = ENT_O1;
      endcase
    end else begin
      unique case (op)
        8'h02: e = ENT_LJMP;
        8'h05: e = ENT_D2;
        8'h10: e = ENT_BR;
        8'h12: e = ENT_LCALL;
        8'h15: e = ENT_D2;
        8'h20: e = ENT_BR;
        8'h24: e = ENT_I2;
        8'h25: e = ENT_D2;
        8'h30: e = ENT_BR;
        8'h34: e = ENT_I2;
        8'h35: e = ENT_D2;
        8'h40: e = ENT_RC;
        8'h42: e = ENT_DX;
        8'h43: e = ENT_DI;
        8'h44: e = ENT_I2;
        8'h45: e = ENT_D2;
        8'h50: e = ENT_RC;
        8'h52: e = ENT_DX;
        8'h53: e = ENT_DI;
        8'h54: e = ENT_I2;
        8'h55: e = ENT_D2;
        8'h60: e = ENT_RC;
        8'h62: e = ENT_DX;
        8'h63: e = ENT_DI;
        8'h64: e = ENT_I2;
        8'h65: e = ENT_D2;
        8'h70: e = ENT_RC;
        8'h72: e = ENT_B2;
        8'h74: e = ENT_I2;
        8'h75: e = ENT_DI;
        8'h80: e = ENT_SJMP;
        8'h82: e = ENT_B2;
        8'h85: e = ENT_DD;
        8'h90: e = ENT_DPTR;
        8'h92: e = ENT_BX;
        8'h94: e = ENT_I2;
        8'h95: e = ENT_D2;
        8'hA0: e = ENT_B2;
        8'hA2: e = ENT_B2;
        8'hB0: e = ENT_B2;
        8'hB2: e = ENT_B2;
        8'hB4: e = ENT_IR;
        8'hB5: e = ENT_DR;
        8'hC0: e = ENT_D2;
        8'hC2: e = ENT_B2;
        8'hC5: e = ENT_D2;
        8'hD0: e = ENT_D2;
        8'hD2: e = ENT_B2;
        8'hD5: e = ENT_DR;
        8'hE5: e = ENT_D2;
        8'hF5: e = ENT_DX;
        default: e = ENT_O1;
      endcase
    end
    return e;
  endfunction

  function automatic logic is_target_kind(input arg_kind_t k);
    return (k == KIND_ADDR11) || (k == KIND_ADDR16) || (k == KIND_REL);
  endfunction

  function automatic logic uses_byte(input arg_kind_t k);
    return (k != KIND_NONE) && (k != KIND_IMPL);
  endfunction

endpackage

// ===== rtl/core/mcs51pd_if.sv =====
`timescale 1ns / 1ps

interface mcs51pd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [7:0]  second_byte;
  logic [7:0]  third_byte;
  logic [19:0] instr_address;
  logic [1:0]  bytes_left;

  modport source (
    output valid, opcode, second_byte, third_byte, instr_address, bytes_left,
    input  ready
  );
  modport sink (
    input  valid, opcode, second_byte, third_byte, instr_address, bytes_left,
    output ready
  );
endinterface

interface mcs51pd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         instr_length;
  logic [3:0]         first_kind;
  logic [3:0]         second_kind;
  logic signed [21:0] first_value;
  logic signed [21:0] second_value;
  logic               is_jump;
  logic               is_cond_jump;
  logic               has_target;
  logic signed [21:0] target_address;
  logic               out_of_data;

  modport source (
    output valid, instr_length, first_kind, second_kind, first_value, second_value,
           is_jump, is_cond_jump, has_target, target_address, out_of_data,
    input  ready
  );
  modport sink (
    input  valid, instr_length, first_kind, second_kind, first_value, second_value,
           is_jump, is_cond_jump, has_target, target_address, out_of_data,
    output ready
  );
endinterface

// ===== rtl/core/mcs51_instruction_predecoder.sv =====
`timescale 1ns / 1ps

// Length and branch-target predecoder for one 8051 instruction.
//
// in_chan carries one request per instruction: the opcode byte, the two bytes
// that follow it, the code address of the opcode and how many bytes are
// available (saturated at three). out_chan returns one result per request:
// length, argument kinds and values, jump flags and the branch target. When
// fewer bytes are available than the instruction needs, only the length and
// the out-of-data flag are set and every other field is zero.
//
// The datapath has three register stages: table lookup and next-address add,
// argument decode, then target selection into the output register. A new
// request is taken every cycle unless out_chan stalls with all stages full.
// Each stage carries its own valid bit; when out_chan stalls, full stages
// hold and empty stages keep filling, so in_chan.ready drops only once all
// three stages hold waiting work. Reset clears the valid bits only; the data
// registers are not reset.
module mcs51_instruction_predecoder (
  input logic                 clk,
  input logic                 rst_n,
  mcs51pd_in_if.sink          in_chan,
  mcs51pd_out_if.source       out_chan
);
  import mcs51pd_pkg::*;

  // Stage handshake: a stage can load when it is empty or its contents move on.
  logic s1_rdy;
  logic s2_rdy;
  logic out_rdy;

  // Stage 1: table entry and fall-through address.
  logic        s1_vld_r;
  logic [7:0]  s1_op_r;
  logic [7:0]  s1_b1_r;
  logic [7:0]  s1_b2_r;
  logic [19:0] s1_addr_r;
  dec_entry_t  s1_ent_r;
  logic [20:0] s1_next_r;
  logic        s1_ood_r;
  dec_entry_t  s1_ent_nxt;
  logic [20:0] s1_next_nxt;
  logic        s1_ood_nxt;

  // Stage 2: decoded argument values.
  logic               s2_vld_r;
  dec_entry_t         s2_ent_r;
  logic               s2_ood_r;
  logic signed [21:0] s2_v1_r;
  logic signed [21:0] s2_v2_r;
  logic signed [21:0] s2_v1_nxt;
  logic signed [21:0] s2_v2_nxt;
  logic [7:0]         arg2_b0;
  logic [7:0]         arg2_b1;

  // Output register.
  logic               out_vld_r;
  logic [1:0]         out_len_r;
  logic [3:0]         out_k1_r;
  logic [3:0]         out_k2_r;
  logic signed [21:0] out_v1_r;
  logic signed [21:0] out_v2_r;
  logic               out_jump_r;
  logic               out_cond_r;
  logic               out_has_r;
  logic signed [21:0] out_tgt_r;
  logic               out_ood_r;
  logic               out_has_nxt;
  logic signed [21:0] out_tgt_nxt;

  assign out_rdy       = !out_vld_r || out_chan.ready;
  assign s2_rdy        = !s2_vld_r || out_rdy;
  assign s1_rdy        = !s1_vld_r || s2_rdy;
  assign in_chan.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= in_chan.valid;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
      end
      if (out_rdy) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // ---------------- Stage 1 ----------------
  always_comb begin
    s1_ent_nxt  = decode_entry(in_chan.opcode);
    s1_next_nxt = {1'b0, in_chan.instr_address} + {19'd0, s1_ent_nxt.len};
    s1_ood_nxt  = in_chan.bytes_left < s1_ent_nxt.len;
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_chan.valid) begin
      s1_op_r   <= in_chan.opcode;
      s1_b1_r   <= in_chan.second_byte;
      s1_b2_r   <= in_chan.third_byte;
      s1_addr_r <= in_chan.instr_address;
      s1_ent_r  <= s1_ent_nxt;
      s1_next_r <= s1_next_nxt;
      s1_ood_r  <= s1_ood_nxt;
    end
  end

  // ---------------- Stage 2 ----------------
  // The second argument starts after a first one that takes operand bytes.
  // A two-byte first argument never has a second one, so at most one byte
  // is skipped; past the third byte the operand reads as zero.
  always_comb begin
    if (uses_byte(s1_ent_r.k1)) begin
      arg2_b0 = s1_b2_r;
      arg2_b1 = 8'd0;
    end else begin
      arg2_b0 = s1_b1_r;
      arg2_b1 = s1_b2_r;
    end
  end

  mcs51pd_arg_dec u_arg1 (
    .kind      (s1_ent_r.k1),
    .b0        (s1_b1_r),
    .b1        (s1_b2_r),
    .opcode    (s1_op_r),
    .addr      (s1_addr_r),
    .next_addr (s1_next_r),
    .value     (s2_v1_nxt)
  );

  mcs51pd_arg_dec u_arg2 (
    .kind      (s1_ent_r.k2),
    .b0        (arg2_b0),
    .b1        (arg2_b1),
    .opcode    (s1_op_r),
    .addr      (s1_addr_r),
    .next_addr (s1_next_r),
    .value     (s2_v2_nxt)
  );

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_ent_r <= s1_ent_r;
      s2_ood_r <= s1_ood_r;
      s2_v1_r  <= s2_v1_nxt;
      s2_v2_r  <= s2_v2_nxt;
    end
  end

  // ---------------- Stage 3 ----------------
  // The later target-kind argument supplies the branch target.
  always_comb begin
    out_has_nxt = is_target_kind(s2_ent_r.k1) || is_target_kind(s2_ent_r.k2);
    if (is_target_kind(s2_ent_r.k2)) begin
      out_tgt_nxt = s2_v2_r;
    end else if (is_target_kind(s2_ent_r.k1)) begin
      out_tgt_nxt = s2_v1_r;
    end else begin
      out_tgt_nxt = '0;
    end
  end

  // An instruction running past the available bytes reports only its length.
  always_ff @(posedge clk) begin
    if (out_rdy && s2_vld_r) begin
      out_len_r <= s2_ent_r.len;
      out_ood_r <= s2_ood_r;
      if (s2_ood_r) begin
        out_k1_r   <= KIND_NONE;
        out_k2_r   <= KIND_NONE;
        out_v1_r   <= '0;
        out_v2_r   <= '0;
        out_jump_r <= 1'b0;
        out_cond_r <= 1'b0;
        out_has_r  <= 1'b0;
        out_tgt_r  <= '0;
      end else begin
        out_k1_r   <= s2_ent_r.k1;
        out_k2_r   <= s2_ent_r.k2;
        out_v1_r   <= s2_v1_r;
        out_v2_r   <= s2_v2_r;
        out_jump_r <= s2_ent_r.jump;
        out_cond_r <= s2_ent_r.cond;
        out_has_r  <= out_has_nxt;
        out_tgt_r  <= out_tgt_nxt;
      end
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.instr_length   = out_len_r;
  assign out_chan.first_kind     = out_k1_r;
  assign out_chan.second_kind    = out_k2_r;
  assign out_chan.first_value    = out_v1_r;
  assign out_chan.second_value   = out_v2_r;
  assign out_chan.is_jump        = out_jump_r;
  assign out_chan.is_cond_jump   = out_cond_r;
  assign out_chan.has_target     = out_has_r;
  assign out_chan.target_address = out_tgt_r;
  assign out_chan.out_of_data    = out_ood_r;

  // ---------------- Assertions ----------------
  a_ood_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ood_r |-> out_k1_r == KIND_NONE && out_k2_r == KIND_NONE &&
      out_v1_r == '0 && out_v2_r == '0 && !out_has_r && out_tgt_r == '0 &&
      !out_jump_r && !out_cond_r)
    else $error("out-of-data result carries decoded fields");

  a_target_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ood_r |-> out_has_r == (
      out_k1_r == KIND_ADDR11 || out_k1_r == KIND_ADDR16 || out_k1_r == KIND_REL ||
      out_k2_r == KIND_ADDR11 || out_k2_r == KIND_ADDR16 || out_k2_r == KIND_REL))
    else $error("has_target disagrees with argument kinds");

  a_length_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_len_r != 2'd0 && !(out_jump_r && out_cond_r))
    else $error("bad length or both jump flags set");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !out_rdy |=> s2_vld_r && $stable(s2_v1_r) && $stable(s2_v2_r))
    else $error("stage 2 lost its contents during a stall");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_rdy |=> s2_vld_r)
    else $error("stage 1 request dropped on its way to stage 2");

endmodule

// ===== rtl/core/mcs51pd_arg_dec.sv =====
`timescale 1ns / 1ps

// Decodes one instruction argument from its operand bytes.
module mcs51pd_arg_dec (
  input  mcs51pd_pkg::arg_kind_t kind,
  input  logic [7:0]             b0,
  input  logic [7:0]             b1,
  input  logic [7:0]             opcode,
  input  logic [19:0]            addr,
  input  logic [20:0]            next_addr,
  output logic signed [21:0]     value
);
  import mcs51pd_pkg::*;

  logic [15:0] raw16;
  logic [19:0] bank_base;
  logic [19:0] addr16;
  logic [19:0] addr11;
  logic [7:0]  page_bits;
  logic [21:0] rel_sum;

  assign raw16     = {b0, b1};
  assign page_bits = opcode & ADDR11_PAGE_BITS;

  // Low 16 KB of a long address is moved into the bank the fetch sits in.
  always_comb begin
    priority if (addr >= BANK3_BASE) begin
      bank_base = BANK3_BASE;
    end else if (addr >= BANK2_BASE) begin
      bank_base = BANK2_BASE;
    end else if (addr >= BANK1_BASE) begin
      bank_base = BANK1_BASE;
    end else if (addr >= BANK0_BASE) begin
      bank_base = BANK0_BASE;
    end else begin
      bank_base = '0;
    end
  end

  assign addr16 = (raw16 < BANK_SIZE) ? (bank_base + {4'd0, raw16}) : {4'd0, raw16};

  // Page bits, operand byte and page number occupy disjoint bit ranges.
  assign addr11  = (next_addr[19:0] & PAGE_MASK) | {9'd0, page_bits[7:5], b0};
  assign rel_sum = {1'b0, next_addr} + {{14{b0[7]}}, b0};

  always_comb begin
    unique case (kind)
      KIND_ADDR11:  value = signed'({2'd0, addr11});
      KIND_ADDR16:  value = signed'({2'd0, addr16});
      KIND_DIRECT,
      KIND_IMMED,
      KIND_BIT:     value = signed'({14'd0, b0});
      KIND_IMMED16: value = signed'({6'd0, raw16});
      KIND_REL:     value = signed'(rel_sum);
      default:      value = '0;
    endcase
  end

endmodule
